// ===== rtl/core/chg_pkg.sv =====
// Shared types and codes for the convex hull controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package chg_pkg;

  // Point store read address sources
  localparam logic [1:0] PS_ASEL_CTRL = 2'd0;
  localparam logic [1:0] PS_ASEL_KEY  = 2'd1;
  localparam logic [1:0] PS_ASEL_CAND = 2'd2;

  // Order list write data sources
  localparam logic [1:0] OL_WSEL_CTRL = 2'd0;
  localparam logic [1:0] OL_WSEL_KEY  = 2'd1;
  localparam logic [1:0] OL_WSEL_CAND = 2'd2;

  // Multiplier operand pairs
  localparam logic [2:0] MUL_XA_YB = 3'd0;
  localparam logic [2:0] MUL_YA_XB = 3'd1;
  localparam logic [2:0] MUL_XA_XA = 3'd2;
  localparam logic [2:0] MUL_YA_YA = 3'd3;
  localparam logic [2:0] MUL_XB_XB = 3'd4;
  localparam logic [2:0] MUL_YB_YB = 3'd5;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       in_ready;
    logic       ps_we;
    logic       ps_re;
    logic [1:0] ps_asel;
    logic       ol_we;
    logic       ol_re;
    logic [1:0] ol_wsel;
    logic       hs_we;
    logic       hs_re;
    logic       key_ld;
    logic       cand_ld_ol;
    logic       cand_ld_hs;
    logic       ld_o;
    logic       ld_a;
    logic       ld_b;
    logic       diff_en;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic       emit;
    logic       out_last;
    logic       out_empty;
    logic       ovf_set;
    logic       ovf_clr;
  } chg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic better;
    logic acc_pos;
    logic acc_neg;
    logic out_busy;
  } chg_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/chg_in_if.sv =====
// Point input channel: valid/ready handshake with one point per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface chg_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/chg_out_if.sv =====
// Hull output channel: valid/ready handshake with one vertex per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface chg_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_y;
  logic                         hull_last;
  logic                         hull_empty;
  logic                         points_dropped;

  modport source (output valid, hull_x, hull_y, hull_last, hull_empty, points_dropped,
                  input ready);
  modport sink   (input valid, hull_x, hull_y, hull_last, hull_empty, points_dropped,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/chg_dp.sv =====
// Datapath: point, order and stack memories, operand registers, multiply-accumulate.
`timescale 1ns / 1ps
`default_nettype none

module chg_dp #(
  parameter int MAX_PTS    = 64,
  parameter int COORD_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire chg_pkg::chg_cmd_t          cmd,
  input  wire [$clog2(MAX_PTS)-1:0]       ps_addr,
  input  wire [$clog2(MAX_PTS)-1:0]       ol_addr,
  input  wire [$clog2(MAX_PTS)-1:0]       hs_addr,
  input  wire [$clog2(MAX_PTS)-1:0]       wval,
  output chg_pkg::chg_sts_t               sts,
  chg_in_if.sink                          pts,
  chg_out_if.source                       hull
);
  localparam int IW = $clog2(MAX_PTS);
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int AW = PW + 1;

  // Memories
  logic [2*CB-1:0] ps_mem [MAX_PTS];
  logic [IW-1:0]   ol_mem [MAX_PTS];
  logic [IW-1:0]   hs_mem [MAX_PTS];

  logic [2*CB-1:0] pt_rd;
  logic [IW-1:0]   ol_rd;
  logic [IW-1:0]   hs_rd;

  logic [IW-1:0]   key;
  logic [IW-1:0]   cand;
  logic [IW-1:0]   ps_a;
  logic [IW-1:0]   ol_wd;

  logic signed [CB-1:0] rx, ry;
  logic signed [CB-1:0] ox, oy, ax, ay, bx, by;
  logic signed [DW-1:0] dxa, dya, dxb, dyb;
  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;

  logic                 ovf;
  logic                 ov;
  logic signed [CB-1:0] hx, hy;
  logic                 hl, he, hd;

  assign rx = pt_rd[2*CB-1:CB];
  assign ry = pt_rd[CB-1:0];

  // Select point store address and order list write data
  always_comb begin
    case (cmd.ps_asel)
      chg_pkg::PS_ASEL_KEY:  ps_a = key;
      chg_pkg::PS_ASEL_CAND: ps_a = cand;
      default:               ps_a = ps_addr;
    endcase
    case (cmd.ol_wsel)
      chg_pkg::OL_WSEL_KEY:  ol_wd = key;
      chg_pkg::OL_WSEL_CAND: ol_wd = cand;
      default:               ol_wd = wval;
    endcase
  end

  // Point store: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.ps_we) begin
      ps_mem[ps_a] <= {pts.point_x, pts.point_y};
    end
    if (cmd.ps_re) begin
      pt_rd <= ps_mem[ps_a];
    end
  end

  // Order list
  always_ff @(posedge clk) begin
    if (cmd.ol_we) begin
      ol_mem[ol_addr] <= ol_wd;
    end
    if (cmd.ol_re) begin
      ol_rd <= ol_mem[ol_addr];
    end
  end

  // Hull stack; a push always takes the current point from the order list read
  always_ff @(posedge clk) begin
    if (cmd.hs_we) begin
      hs_mem[hs_addr] <= ol_rd;
    end
    if (cmd.hs_re) begin
      hs_rd <= hs_mem[hs_addr];
    end
  end

  // Index and operand registers
  always_ff @(posedge clk) begin
    if (cmd.key_ld) begin
      key <= ol_rd;
    end
    if (cmd.cand_ld_ol) begin
      cand <= ol_rd;
    end else if (cmd.cand_ld_hs) begin
      cand <= hs_rd;
    end
    if (cmd.ld_o) begin
      ox <= rx;
      oy <= ry;
    end
    if (cmd.ld_a) begin
      ax <= rx;
      ay <= ry;
    end
    if (cmd.ld_b) begin
      bx <= rx;
      by <= ry;
    end
    if (cmd.diff_en) begin
      dxa <= DW'(ax) - DW'(ox);
      dya <= DW'(ay) - DW'(oy);
      dxb <= DW'(bx) - DW'(ox);
      dyb <= DW'(by) - DW'(oy);
    end
  end

  // Pick multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      chg_pkg::MUL_XA_YB: begin opa = dxa; opb = dyb; end
      chg_pkg::MUL_YA_XB: begin opa = dya; opb = dxb; end
      chg_pkg::MUL_XA_XA: begin opa = dxa; opb = dxa; end
      chg_pkg::MUL_YA_YA: begin opa = dya; opb = dya; end
      chg_pkg::MUL_XB_XB: begin opa = dxb; opb = dxb; end
      chg_pkg::MUL_YB_YB: begin opa = dyb; opb = dyb; end
      default:            begin opa = dxa; opb = dyb; end
    endcase
  end

  // Multiply, then accumulate the previous product
  always_ff @(posedge clk) begin
    prod <= opa * opb;
    case (cmd.acc_op)
      chg_pkg::ACC_LOAD: acc <= AW'(prod);
      chg_pkg::ACC_ADD:  acc <= acc + AW'(prod);
      chg_pkg::ACC_SUB:  acc <= acc - AW'(prod);
      default:           acc <= acc;
    endcase
  end

  // Track dropped points for the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (cmd.ovf_clr) begin
      ovf <= 1'b0;
    end else if (cmd.ovf_set) begin
      ovf <= 1'b1;
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (cmd.emit) begin
      ov <= 1'b1;
    end else if (hull.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hx <= cmd.out_empty ? '0 : rx;
      hy <= cmd.out_empty ? '0 : ry;
      hl <= cmd.out_last;
      he <= cmd.out_empty;
      hd <= ovf;
    end
  end

  assign pts.ready           = cmd.in_ready;
  assign hull.valid          = ov;
  assign hull.hull_x         = hx;
  assign hull.hull_y         = hy;
  assign hull.hull_last      = hl;
  assign hull.hull_empty     = he;
  assign hull.points_dropped = hd;

  assign sts.in_valid = pts.valid;
  assign sts.in_last  = pts.last_point;
  assign sts.better   = (ry < oy) || ((ry == oy) && (rx < ox));
  assign sts.acc_pos  = (acc > 0);
  assign sts.acc_neg  = acc[AW-1];
  assign sts.out_busy = ov;

endmodule

`default_nettype wire

// ===== rtl/core/chg_ctrl.sv =====
// Controller: sequences load, pivot search, angular sort, scan and emission.
`timescale 1ns / 1ps
`default_nettype none

module chg_ctrl #(
  parameter int MAX_PTS = 64
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire chg_pkg::chg_sts_t     sts,
  output chg_pkg::chg_cmd_t          cmd,
  output logic [$clog2(MAX_PTS)-1:0] ps_addr,
  output logic [$clog2(MAX_PTS)-1:0] ol_addr,
  output logic [$clog2(MAX_PTS)-1:0] hs_addr,
  output logic [$clog2(MAX_PTS)-1:0] wval
);
  localparam int IW = $clog2(MAX_PTS);
  localparam int CW = $clog2(MAX_PTS + 1);

  localparam logic [5:0] S_LOAD   = 6'd0;
  localparam logic [5:0] S_CHK    = 6'd1;
  localparam logic [5:0] S_EMPTY  = 6'd2;
  localparam logic [5:0] S_PV_RD  = 6'd3;
  localparam logic [5:0] S_PV_CMP = 6'd4;
  localparam logic [5:0] S_OB0    = 6'd5;
  localparam logic [5:0] S_OB     = 6'd6;
  localparam logic [5:0] S_ST_RK  = 6'd7;
  localparam logic [5:0] S_ST_K   = 6'd8;
  localparam logic [5:0] S_ST_RA  = 6'd9;
  localparam logic [5:0] S_ST_LA  = 6'd10;
  localparam logic [5:0] S_ST_J   = 6'd11;
  localparam logic [5:0] S_ST_C   = 6'd12;
  localparam logic [5:0] S_ST_RB  = 6'd13;
  localparam logic [5:0] S_ST_LB  = 6'd14;
  localparam logic [5:0] S_DF     = 6'd15;
  localparam logic [5:0] S_M1     = 6'd16;
  localparam logic [5:0] S_M2     = 6'd17;
  localparam logic [5:0] S_M3     = 6'd18;
  localparam logic [5:0] S_TST    = 6'd19;
  localparam logic [5:0] S_D1     = 6'd20;
  localparam logic [5:0] S_D2     = 6'd21;
  localparam logic [5:0] S_D3     = 6'd22;
  localparam logic [5:0] S_D4     = 6'd23;
  localparam logic [5:0] S_D5     = 6'd24;
  localparam logic [5:0] S_DTST   = 6'd25;
  localparam logic [5:0] S_ST_SH  = 6'd26;
  localparam logic [5:0] S_ST_INS = 6'd27;
  localparam logic [5:0] S_SC_R0  = 6'd28;
  localparam logic [5:0] S_SC_W0  = 6'd29;
  localparam logic [5:0] S_SC_R1  = 6'd30;
  localparam logic [5:0] S_SC_W1  = 6'd31;
  localparam logic [5:0] S_SC_RC  = 6'd32;
  localparam logic [5:0] S_SC_K   = 6'd33;
  localparam logic [5:0] S_SC_RB  = 6'd34;
  localparam logic [5:0] S_SC_LB  = 6'd35;
  localparam logic [5:0] S_SC_CHK = 6'd36;
  localparam logic [5:0] S_SC_C1  = 6'd37;
  localparam logic [5:0] S_SC_C2  = 6'd38;
  localparam logic [5:0] S_SC_C3  = 6'd39;
  localparam logic [5:0] S_SC_C4  = 6'd40;
  localparam logic [5:0] S_SC_C5  = 6'd41;
  localparam logic [5:0] S_SC_C6  = 6'd42;
  localparam logic [5:0] S_SC_PSH = 6'd43;
  localparam logic [5:0] S_EM_RH  = 6'd44;
  localparam logic [5:0] S_EM_C   = 6'd45;
  localparam logic [5:0] S_EM_RP  = 6'd46;
  localparam logic [5:0] S_EM_W   = 6'd47;

  logic [5:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] sp, sp_next;
  logic [IW-1:0] piv, piv_next;
  logic          in_scan, in_scan_next;

  logic [CW-1:0] last_i;
  logic [CW-1:0] j_m1;
  logic [CW-1:0] sp_m1;
  logic [CW-1:0] sp_m2;
  logic          is_last_i;

  assign last_i    = cnt - CW'(1);
  assign j_m1      = j - CW'(1);
  assign sp_m1     = sp - CW'(1);
  assign sp_m2     = sp - CW'(2);
  assign is_last_i = (i == last_i);

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      cnt     <= '0;
      i       <= '0;
      j       <= '0;
      sp      <= '0;
      piv     <= '0;
      in_scan <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      i       <= i_next;
      j       <= j_next;
      sp      <= sp_next;
      piv     <= piv_next;
      in_scan <= in_scan_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd          = '0;
    state_next   = state;
    cnt_next     = cnt;
    i_next       = i;
    j_next       = j;
    sp_next      = sp;
    piv_next     = piv;
    in_scan_next = in_scan;
    ps_addr      = i[IW-1:0];
    ol_addr      = i[IW-1:0];
    hs_addr      = i[IW-1:0];
    wval         = i[IW-1:0];

    case (state)
      // Store incoming points, drop those beyond capacity
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        ps_addr      = cnt[IW-1:0];
        if (sts.in_valid) begin
          if (cnt < CW'(MAX_PTS)) begin
            cmd.ps_we = 1'b1;
            cnt_next  = cnt + CW'(1);
          end else begin
            cmd.ovf_set = 1'b1;
          end
          if (sts.in_last) begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        i_next = '0;
        state_next = (cnt < CW'(3)) ? S_EMPTY : S_PV_RD;
      end
      S_EMPTY: begin
        if (!sts.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.out_last  = 1'b1;
          cmd.out_empty = 1'b1;
          cmd.ovf_clr   = 1'b1;
          cnt_next      = '0;
          sp_next       = '0;
          state_next    = S_LOAD;
        end
      end

      // Pivot search: lowest y, then lowest x, earliest on ties
      S_PV_RD: begin
        cmd.ps_re  = 1'b1;
        state_next = S_PV_CMP;
      end
      S_PV_CMP: begin
        if (i == '0 || sts.better) begin
          cmd.ld_o = 1'b1;
          piv_next = i[IW-1:0];
        end
        if (is_last_i) begin
          state_next = S_OB0;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_PV_RD;
        end
      end

      // Build the order list: pivot first, then the rest in load order
      S_OB0: begin
        cmd.ol_we   = 1'b1;
        cmd.ol_wsel = chg_pkg::OL_WSEL_CTRL;
        ol_addr     = '0;
        wval        = piv;
        j_next      = CW'(1);
        i_next      = '0;
        state_next  = S_OB;
      end
      S_OB: begin
        ol_addr = j[IW-1:0];
        if (i[IW-1:0] != piv) begin
          cmd.ol_we = 1'b1;
          j_next    = j + CW'(1);
        end
        if (is_last_i) begin
          i_next     = CW'(2);
          state_next = S_ST_RK;
        end else begin
          i_next = i + CW'(1);
        end
      end

      // Insertion sort by angle about the pivot
      S_ST_RK: begin
        cmd.ol_re  = 1'b1;
        state_next = S_ST_K;
      end
      S_ST_K: begin
        cmd.key_ld = 1'b1;
        j_next     = i;
        state_next = S_ST_RA;
      end
      S_ST_RA: begin
        cmd.ps_re   = 1'b1;
        cmd.ps_asel = chg_pkg::PS_ASEL_KEY;
        state_next  = S_ST_LA;
      end
      S_ST_LA: begin
        cmd.ld_a   = 1'b1;
        state_next = S_ST_J;
      end
      S_ST_J: begin
        if (j > CW'(1)) begin
          cmd.ol_re  = 1'b1;
          ol_addr    = j_m1[IW-1:0];
          state_next = S_ST_C;
        end else begin
          state_next = S_ST_INS;
        end
      end
      S_ST_C: begin
        cmd.cand_ld_ol = 1'b1;
        state_next     = S_ST_RB;
      end
      S_ST_RB: begin
        cmd.ps_re   = 1'b1;
        cmd.ps_asel = chg_pkg::PS_ASEL_CAND;
        state_next  = S_ST_LB;
      end
      S_ST_LB: begin
        cmd.ld_b   = 1'b1;
        state_next = S_DF;
      end

      // Cross product of (A - O) and (B - O)
      S_DF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = chg_pkg::MUL_XA_YB;
        state_next  = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = chg_pkg::MUL_YA_XB;
        cmd.acc_op  = chg_pkg::ACC_LOAD;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.acc_op = chg_pkg::ACC_SUB;
        state_next = S_TST;
      end
      S_TST: begin
        if (in_scan) begin
          if (sts.acc_pos) begin
            state_next = S_SC_PSH;
          end else begin
            sp_next    = sp_m1;
            state_next = S_SC_CHK;
          end
        end else if (sts.acc_pos) begin
          state_next = S_ST_SH;
        end else if (sts.acc_neg) begin
          state_next = S_ST_INS;
        end else begin
          state_next = S_D1;
        end
      end

      // Collinear: compare squared distances, nearest first
      S_D1: begin
        cmd.mul_sel = chg_pkg::MUL_XA_XA;
        state_next  = S_D2;
      end
      S_D2: begin
        cmd.mul_sel = chg_pkg::MUL_YA_YA;
        cmd.acc_op  = chg_pkg::ACC_LOAD;
        state_next  = S_D3;
      end
      S_D3: begin
        cmd.mul_sel = chg_pkg::MUL_XB_XB;
        cmd.acc_op  = chg_pkg::ACC_ADD;
        state_next  = S_D4;
      end
      S_D4: begin
        cmd.mul_sel = chg_pkg::MUL_YB_YB;
        cmd.acc_op  = chg_pkg::ACC_SUB;
        state_next  = S_D5;
      end
      S_D5: begin
        cmd.acc_op = chg_pkg::ACC_SUB;
        state_next = S_DTST;
      end
      S_DTST: begin
        state_next = sts.acc_neg ? S_ST_SH : S_ST_INS;
      end
      S_ST_SH: begin
        cmd.ol_we   = 1'b1;
        cmd.ol_wsel = chg_pkg::OL_WSEL_CAND;
        ol_addr     = j[IW-1:0];
        j_next      = j_m1;
        state_next  = S_ST_J;
      end
      S_ST_INS: begin
        cmd.ol_we   = 1'b1;
        cmd.ol_wsel = chg_pkg::OL_WSEL_KEY;
        ol_addr     = j[IW-1:0];
        if (is_last_i) begin
          in_scan_next = 1'b1;
          state_next   = S_SC_R0;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_ST_RK;
        end
      end

      // Scan: seed the stack with the first two sorted points
      S_SC_R0: begin
        cmd.ol_re  = 1'b1;
        ol_addr    = '0;
        state_next = S_SC_W0;
      end
      S_SC_W0: begin
        cmd.hs_we  = 1'b1;
        hs_addr    = '0;
        state_next = S_SC_R1;
      end
      S_SC_R1: begin
        cmd.ol_re  = 1'b1;
        ol_addr    = IW'(1);
        state_next = S_SC_W1;
      end
      S_SC_W1: begin
        cmd.hs_we  = 1'b1;
        hs_addr    = IW'(1);
        sp_next    = CW'(2);
        i_next     = CW'(2);
        state_next = S_SC_RC;
      end
      S_SC_RC: begin
        cmd.ol_re  = 1'b1;
        state_next = S_SC_K;
      end
      S_SC_K: begin
        cmd.key_ld = 1'b1;
        state_next = S_SC_RB;
      end
      S_SC_RB: begin
        cmd.ps_re   = 1'b1;
        cmd.ps_asel = chg_pkg::PS_ASEL_KEY;
        state_next  = S_SC_LB;
      end
      S_SC_LB: begin
        cmd.ld_b   = 1'b1;
        state_next = S_SC_CHK;
      end
      // Pop while the turn is not counter-clockwise
      S_SC_CHK: begin
        hs_addr = sp_m2[IW-1:0];
        if (sp >= CW'(2)) begin
          cmd.hs_re  = 1'b1;
          state_next = S_SC_C1;
        end else begin
          state_next = S_SC_PSH;
        end
      end
      S_SC_C1: begin
        cmd.cand_ld_hs = 1'b1;
        state_next     = S_SC_C2;
      end
      S_SC_C2: begin
        cmd.ps_re   = 1'b1;
        cmd.ps_asel = chg_pkg::PS_ASEL_CAND;
        state_next  = S_SC_C3;
      end
      S_SC_C3: begin
        cmd.ld_o   = 1'b1;
        cmd.hs_re  = 1'b1;
        hs_addr    = sp_m1[IW-1:0];
        state_next = S_SC_C4;
      end
      S_SC_C4: begin
        cmd.cand_ld_hs = 1'b1;
        state_next     = S_SC_C5;
      end
      S_SC_C5: begin
        cmd.ps_re   = 1'b1;
        cmd.ps_asel = chg_pkg::PS_ASEL_CAND;
        state_next  = S_SC_C6;
      end
      S_SC_C6: begin
        cmd.ld_a   = 1'b1;
        state_next = S_DF;
      end
      S_SC_PSH: begin
        cmd.hs_we = 1'b1;
        hs_addr   = sp[IW-1:0];
        sp_next   = sp + CW'(1);
        if (is_last_i) begin
          i_next       = '0;
          in_scan_next = 1'b0;
          state_next   = S_EM_RH;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_SC_RC;
        end
      end

      // Emit the stack from bottom to top
      S_EM_RH: begin
        cmd.hs_re  = 1'b1;
        state_next = S_EM_C;
      end
      S_EM_C: begin
        cmd.cand_ld_hs = 1'b1;
        state_next     = S_EM_RP;
      end
      S_EM_RP: begin
        cmd.ps_re   = 1'b1;
        cmd.ps_asel = chg_pkg::PS_ASEL_CAND;
        state_next  = S_EM_W;
      end
      S_EM_W: begin
        if (!sts.out_busy) begin
          cmd.emit     = 1'b1;
          cmd.out_last = ((i + CW'(1)) == sp);
          if ((i + CW'(1)) == sp) begin
            cmd.ovf_clr = 1'b1;
            cnt_next    = '0;
            sp_next     = '0;
            state_next  = S_LOAD;
          end else begin
            i_next     = i + CW'(1);
            state_next = S_EM_RH;
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/convex_hull_graham_scan.sv =====
// Top level: Graham scan convex hull over a streamed set of points.
//
//   channel | modport | payload                                        | per transaction
//   pts     | sink    | point_x, point_y, last_point                   | one point
//   hull    | source  | hull_x, hull_y, hull_last, hull_empty,         | one hull vertex
//           |         | points_dropped                                 |
//
// Points load one per cycle while the block is in its load phase. After the
// point marked last, pts.ready stays low while the pivot search, the order
// list build, the insertion sort and the scan run (the sort and the scan on
// one shared multiplier), then while each vertex is emitted, with any wait on
// hull.ready.
// Reset is synchronous and clears control state, the dropped-points flag
// and the output valid flag; memories need no clear.
`timescale 1ns / 1ps
`default_nettype none

module convex_hull_graham_scan #(
  parameter int MAX_PTS    = 64,
  parameter int COORD_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  chg_in_if.sink     pts,
  chg_out_if.source  hull
);
  localparam int IW = $clog2(MAX_PTS);

  chg_pkg::chg_cmd_t cmd;
  chg_pkg::chg_sts_t sts;
  logic [IW-1:0]     ps_addr;
  logic [IW-1:0]     ol_addr;
  logic [IW-1:0]     hs_addr;
  logic [IW-1:0]     wval;

  chg_ctrl #(
    .MAX_PTS (MAX_PTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .sts     (sts),
    .cmd     (cmd),
    .ps_addr (ps_addr),
    .ol_addr (ol_addr),
    .hs_addr (hs_addr),
    .wval    (wval)
  );

  chg_dp #(
    .MAX_PTS    (MAX_PTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .ps_addr (ps_addr),
    .ol_addr (ol_addr),
    .hs_addr (hs_addr),
    .wval    (wval),
    .sts     (sts),
    .pts     (pts),
    .hull    (hull)
  );

endmodule

`default_nettype wire
